// File: rtl/bprc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprc_pkg
// shared types, widths and codes for the per-bone rotation correction block
// ----------------------------------------------------------------------------
package bprc_pkg;

    localparam int BONE_COUNT = 64;
    localparam int SLOT_W     = 6;
    localparam int SLOTS      = 2 ** SLOT_W;

    // datapath widths
    localparam int Q_W       = 16;
    localparam int P1_W      = 32;
    localparam int T_W       = 34;
    localparam int P2_W      = 50;
    localparam int C_W       = 52;
    localparam int MAG_W     = 51;
    localparam int GRP_N     = (MAG_W + 7) / 8;
    localparam int POS_W     = 6;
    localparam int SCALE_BIT = 29;
    localparam int A_W       = 30;
    localparam int SQ_W      = 60;
    localparam int SUM_W     = 62;
    localparam int ROOT_W    = 31;
    localparam int RT_W      = SUM_W + 1;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int QUO_W     = 17;
    localparam int REM_W     = 49;

    localparam logic signed [Q_W-1:0] Q_ONE     = 16'sd32767;
    localparam logic [QUO_W-1:0]      Q_POS_MAX = 17'd32767;
    localparam logic [QUO_W-1:0]      Q_NEG_MAX = 17'd32768;

    typedef enum logic [1:0] {
        MODE_PRE   = 2'd0,
        MODE_POST  = 2'd1,
        MODE_PASS  = 2'd2,
        MODE_APPLY = 2'd3
    } t_mode;

    typedef logic signed [Q_W-1:0] t_q16;
    typedef t_q16 [3:0] t_quat;                 // element 0 is w

    localparam t_quat QUAT_IDENT = {16'sd0, 16'sd0, 16'sd0, Q_ONE};

    typedef struct packed {
        t_mode      mode;
        logic [5:0] bone;
        t_q16       quat_w;
        t_q16       quat_x;
        t_q16       quat_y;
        t_q16       quat_z;
    } t_in_word;

    typedef struct packed {
        t_q16 out_w;
        t_q16 out_x;
        t_q16 out_y;
        t_q16 out_z;
    } t_out_word;

    // control that travels with every stage
    typedef struct packed {
        logic  vld;
        logic  pass;
        t_quat raw;
    } t_meta;

    typedef logic signed [T_W-1:0]  t_t;
    typedef t_t [3:0]               t_tvec;
    typedef logic signed [P2_W-1:0] t_p;
    typedef t_p [3:0][3:0]          t_pmat;
    typedef logic signed [C_W-1:0]  t_c;
    typedef t_c [3:0]               t_cvec;
    typedef logic [A_W-1:0]         t_a;

    typedef struct packed {
        t_meta      meta;
        logic       zero;
        logic [3:0] neg;
        t_a [3:0]   a;
    } t_nrm;

    // hamilton product from the table of pairwise products p[i][j] = a[i] * b[j]
    function automatic t_cvec ham_sum(input t_pmat p);
        t_cvec r;
        r[0] = C_W'($signed(p[0][0])) - C_W'($signed(p[1][1]))
             - C_W'($signed(p[2][2])) - C_W'($signed(p[3][3]));
        r[1] = C_W'($signed(p[0][1])) + C_W'($signed(p[1][0]))
             + C_W'($signed(p[2][3])) - C_W'($signed(p[3][2]));
        r[2] = C_W'($signed(p[0][2])) - C_W'($signed(p[1][3]))
             + C_W'($signed(p[2][0])) + C_W'($signed(p[3][1]));
        r[3] = C_W'($signed(p[0][3])) + C_W'($signed(p[1][2]))
             - C_W'($signed(p[2][1])) + C_W'($signed(p[3][0]));
        return r;
    endfunction

endpackage

// File: rtl/per_bone_rotation_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_bone_rotation_correction
// per-bone pre/post quaternion correction with normalised q1.15 result
// ----------------------------------------------------------------------------
//
//  channel   valid     ready     word                 moves when
//  -------   -------   -------   ------------------   ---------------------
//  in        i_valid   o_ready   i_data (t_in_word)   i_valid && o_ready
//  out       o_valid   i_ready   o_data (t_out_word)  o_valid && i_ready
//
//  one word accepted per cycle while the skid slot is empty; an apply word passes
//  register stages (1 table read, 4 product, 6 normalise, 31 square root, 17 divide, 1 output)
//  write and pass-through words update the tables at acceptance, give no result
//  synchronous active-low reset; tables read as identity and pass-through after
//  a stalled output fills one skid slot, then o_ready drops until it drains
//
module per_bone_rotation_correction import bprc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    logic              w_en;
    logic              w_acc;
    t_meta             w_tab_meta;
    t_quat             w_pre;
    t_quat             w_post;
    t_meta             w_sw_meta;
    t_cvec             w_c;
    t_nrm              w_nrm;
    logic [SUM_W-1:0]  w_sum;
    t_nrm              w_rt_nrm;
    logic [ROOT_W-1:0] w_root;
    logic              w_res_vld;
    t_out_word         w_res;

    logic              r_out_vld;
    t_out_word         r_out;
    logic              r_skid_vld;
    t_out_word         r_skid;

    // the whole pipe moves while the skid slot is empty
    assign w_en    = !r_skid_vld;
    assign w_acc   = i_valid && w_en;
    assign o_ready = w_en;

    // table lookup, also takes the writes
    bprc_tables u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_acc   (w_acc),
        .i_word  (i_data),
        .o_meta  (w_tab_meta),
        .o_pre   (w_pre),
        .o_post  (w_post)
    );

    // pre * rotation * post
    bprc_sandwich u_sandwich (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_meta  (w_tab_meta),
        .i_pre   (w_pre),
        .i_post  (w_post),
        .o_meta  (w_sw_meta),
        .o_c     (w_c)
    );

    // scaling and sum of squares
    bprc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_meta  (w_sw_meta),
        .i_c     (w_c),
        .o_nrm   (w_nrm),
        .o_sum   (w_sum)
    );

    // norm
    bprc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_nrm   (w_nrm),
        .i_sum   (w_sum),
        .o_nrm   (w_rt_nrm),
        .o_root  (w_root)
    );

    // division, saturation, pass-through and zero selection
    bprc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_nrm   (w_rt_nrm),
        .i_root  (w_root),
        .o_vld   (w_res_vld),
        .o_word  (w_res)
    );

    // output register with one skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (w_res_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out     <= w_res;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= w_res;
                r_skid_vld <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// File: rtl/bprc_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprc_tables
// pre/post correction memories and pass-through flags, registered lookup
// ----------------------------------------------------------------------------
module bprc_tables import bprc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_acc,
    input  t_in_word i_word,
    output t_meta    o_meta,
    output t_quat    o_pre,
    output t_quat    o_post
);

    t_quat            r_pre_mem  [SLOTS];
    t_quat            r_post_mem [SLOTS];
    logic [SLOTS-1:0] r_pre_ok;
    logic [SLOTS-1:0] r_post_ok;
    logic [SLOTS-1:0] r_pass;
    t_quat            r_pre_rd;
    t_quat            r_post_rd;
    logic             r_pre_rd_ok;
    logic             r_post_rd_ok;
    t_meta            r_meta;
    t_quat            w_q;
    logic             w_in_range;

    assign w_q        = {i_word.quat_z, i_word.quat_y, i_word.quat_x, i_word.quat_w};
    assign w_in_range = int'(i_word.bone) < BONE_COUNT;

    // entry-written bits: an unwritten entry reads as identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ok  <= '0;
            r_post_ok <= '0;
            r_pass    <= '1;
        end else if (i_acc && w_in_range) begin
            unique case (i_word.mode)
                MODE_PRE: begin
                    r_pre_ok[i_word.bone] <= 1'b1;
                    r_pass[i_word.bone]   <= 1'b0;
                end
                MODE_POST: begin
                    r_post_ok[i_word.bone] <= 1'b1;
                end
                MODE_PASS: begin
                    r_pass[i_word.bone] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && w_in_range && i_word.mode == MODE_PRE) begin
            r_pre_mem[i_word.bone] <= w_q;
        end
        if (i_acc && w_in_range && i_word.mode == MODE_POST) begin
            r_post_mem[i_word.bone] <= w_q;
        end
        if (i_en) begin
            r_pre_rd  <= r_pre_mem[i_word.bone];
            r_post_rd <= r_post_mem[i_word.bone];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.vld <= 1'b0;
        end else if (i_en) begin
            r_meta.vld   <= i_acc && i_word.mode == MODE_APPLY;
            r_meta.pass  <= !w_in_range || r_pass[i_word.bone];
            r_meta.raw   <= w_q;
            r_pre_rd_ok  <= r_pre_ok[i_word.bone];
            r_post_rd_ok <= r_post_ok[i_word.bone];
        end
    end

    assign o_meta = r_meta;
    assign o_pre  = r_pre_rd_ok  ? r_pre_rd  : QUAT_IDENT;
    assign o_post = r_post_rd_ok ? r_post_rd : QUAT_IDENT;

endmodule

// File: rtl/bprc_sandwich.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprc_sandwich
// pre * rotation * post as two hamilton products, four register stages
// ----------------------------------------------------------------------------
module bprc_sandwich import bprc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_meta i_meta,
    input  t_quat i_pre,
    input  t_quat i_post,
    output t_meta o_meta,
    output t_cvec o_c
);

    t_pmat r_pa;
    t_meta r_meta_a;
    t_quat r_post_a;
    t_tvec r_t;
    t_meta r_meta_b;
    t_quat r_post_b;
    t_pmat r_pb;
    t_meta r_meta_c;
    t_cvec r_c;
    t_meta r_meta_d;
    t_cvec w_sum_a;

    assign w_sum_a = ham_sum(r_pa);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_a.vld <= 1'b0;
            r_meta_b.vld <= 1'b0;
            r_meta_c.vld <= 1'b0;
            r_meta_d.vld <= 1'b0;
        end else if (i_en) begin
            // partial products of pre * rotation
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_pa[i][j] <= P2_W'(P1_W'($signed(i_pre[i]))
                                  * P1_W'($signed(i_meta.raw[j])));
                end
            end
            r_meta_a <= i_meta;
            r_post_a <= i_post;
            // first product
            for (int i = 0; i < 4; i++) begin
                r_t[i] <= T_W'(w_sum_a[i]);
            end
            r_meta_b <= r_meta_a;
            r_post_b <= r_post_a;
            // partial products of (pre * rotation) * post
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_pb[i][j] <= P2_W'($signed(r_t[i])) * P2_W'($signed(r_post_b[j]));
                end
            end
            r_meta_c <= r_meta_b;
            r_c      <= ham_sum(r_pb);
            r_meta_d <= r_meta_c;
        end
    end

    assign o_meta = r_meta_d;
    assign o_c    = r_c;

endmodule

// File: rtl/bprc_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprc_norm
// magnitude, leading-one search, scale the largest to [2^29, 2^30), sum of squares
// ----------------------------------------------------------------------------
module bprc_norm import bprc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_meta            i_meta,
    input  t_cvec            i_c,
    output t_nrm             o_nrm,
    output logic [SUM_W-1:0] o_sum
);

    logic [MAG_W-1:0]   r_mag1 [4];
    logic [3:0]         r_neg1;
    logic [MAG_W-1:0]   r_or1;
    t_meta              r_meta1;

    logic [MAG_W-1:0]   r_mag2 [4];
    logic [3:0]         r_neg2;
    logic               r_zero2;
    logic [GRP_N-1:0]   r_nz2;
    logic [2:0]         r_gpos2 [GRP_N];
    t_meta              r_meta2;

    logic [MAG_W-1:0]   r_mag3 [4];
    logic [3:0]         r_neg3;
    logic               r_zero3;
    logic [POS_W-1:0]   r_pos3;
    t_meta              r_meta3;

    t_nrm               r_nrm4;
    t_nrm               r_nrm5;
    logic [SQ_W-1:0]    r_sq5 [4];
    t_nrm               r_nrm6;
    logic [SUM_W-1:0]   r_sum6;

    logic [MAG_W-1:0]   w_mag [4];
    logic [MAG_W-1:0]   w_or;
    logic [GRP_N*8-1:0] w_pad;
    logic [GRP_N-1:0]   w_nz;
    logic [2:0]         w_gpos [GRP_N];
    logic [POS_W-1:0]   w_pos;
    t_a                 w_a [4];

    always_comb begin
        w_or = '0;
        for (int i = 0; i < 4; i++) begin
            w_mag[i] = i_c[i][C_W-1] ? MAG_W'(-i_c[i]) : MAG_W'(i_c[i]);
            w_or     = w_or | w_mag[i];
        end
    end

    // leading one, first within bytes
    always_comb begin
        w_pad = (GRP_N*8)'(r_or1);
        for (int g = 0; g < GRP_N; g++) begin
            w_nz[g]   = |w_pad[g*8 +: 8];
            w_gpos[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (w_pad[g*8 + b]) begin
                    w_gpos[g] = 3'(b);
                end
            end
        end
    end

    // then across bytes
    always_comb begin
        w_pos = '0;
        for (int g = 0; g < GRP_N; g++) begin
            if (r_nz2[g]) begin
                w_pos = POS_W'(g * 8) + POS_W'(r_gpos2[g]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_pos3 >= POS_W'(SCALE_BIT)) begin
                w_a[i] = A_W'(r_mag3[i] >> (r_pos3 - POS_W'(SCALE_BIT)));
            end else begin
                w_a[i] = A_W'(r_mag3[i] << (POS_W'(SCALE_BIT) - r_pos3));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta1.vld     <= 1'b0;
            r_meta2.vld     <= 1'b0;
            r_meta3.vld     <= 1'b0;
            r_nrm4.meta.vld <= 1'b0;
            r_nrm5.meta.vld <= 1'b0;
            r_nrm6.meta.vld <= 1'b0;
        end else if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_mag1[i] <= w_mag[i];
                r_neg1[i] <= i_c[i][C_W-1];
            end
            r_or1   <= w_or;
            r_meta1 <= i_meta;

            r_mag2  <= r_mag1;
            r_neg2  <= r_neg1;
            r_zero2 <= ~|r_or1;
            r_nz2   <= w_nz;
            r_gpos2 <= w_gpos;
            r_meta2 <= r_meta1;

            r_mag3  <= r_mag2;
            r_neg3  <= r_neg2;
            r_zero3 <= r_zero2;
            r_pos3  <= w_pos;
            r_meta3 <= r_meta2;

            r_nrm4.meta <= r_meta3;
            r_nrm4.zero <= r_zero3;
            r_nrm4.neg  <= r_neg3;
            for (int i = 0; i < 4; i++) begin
                r_nrm4.a[i] <= w_a[i];
            end

            r_nrm5 <= r_nrm4;
            for (int i = 0; i < 4; i++) begin
                r_sq5[i] <= SQ_W'(r_nrm4.a[i]) * SQ_W'(r_nrm4.a[i]);
            end

            r_nrm6 <= r_nrm5;
            r_sum6 <= SUM_W'(r_sq5[0]) + SUM_W'(r_sq5[1])
                    + SUM_W'(r_sq5[2]) + SUM_W'(r_sq5[3]);
        end
    end

    assign o_nrm = r_nrm6;
    assign o_sum = r_sum6;

endmodule

// File: rtl/bprc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprc_isqrt
// floor square root, one result bit per register stage
// ----------------------------------------------------------------------------
module bprc_isqrt import bprc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_nrm              i_nrm,
    input  logic [SUM_W-1:0]  i_sum,
    output t_nrm              o_nrm,
    output logic [ROOT_W-1:0] o_root
);

    logic [RT_W-1:0] r_rem [ROOT_W];
    logic [RT_W-1:0] r_res [ROOT_W];
    t_nrm            r_nrm [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (ROOT_W - 1 - s));
        logic [RT_W-1:0] w_rem_in;
        logic [RT_W-1:0] w_res_in;
        logic [RT_W-1:0] w_try;
        t_nrm            w_nrm_in;

        if (s == 0) begin : g_first
            assign w_rem_in = RT_W'(i_sum);
            assign w_res_in = '0;
            assign w_nrm_in = i_nrm;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_res_in = r_res[s-1];
            assign w_nrm_in = r_nrm[s-1];
        end

        assign w_try = w_res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nrm[s].meta.vld <= 1'b0;
            end else if (i_en) begin
                r_nrm[s] <= w_nrm_in;
                if (w_rem_in >= w_try) begin
                    r_rem[s] <= w_rem_in - w_try;
                    r_res[s] <= (w_res_in >> 1) + BIT;
                end else begin
                    r_rem[s] <= w_rem_in;
                    r_res[s] <= w_res_in >> 1;
                end
            end
        end
    end

    assign o_nrm  = r_nrm[ROOT_W-1];
    assign o_root = ROOT_W'(r_res[ROOT_W-1]);

endmodule

// File: rtl/bprc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprc_div
// rounded c * 32768 / norm on four lanes, one quotient bit per stage,
// then saturation and selection of the result word
// ----------------------------------------------------------------------------
module bprc_div import bprc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_nrm              i_nrm,
    input  logic [ROOT_W-1:0] i_root,
    output logic              o_vld,
    output t_out_word         o_word
);

    logic [REM_W-1:0] r_rem [QUO_W][4];
    logic [QUO_W-1:0] r_quo [QUO_W][4];
    logic [DEN_W-1:0] r_den [QUO_W];
    t_nrm             r_nrm [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int K = QUO_W - 1 - s;
        logic [REM_W-1:0] w_rem_in [4];
        logic [QUO_W-1:0] w_quo_in [4];
        logic [DEN_W-1:0] w_den_in;
        logic [REM_W-1:0] w_sub;
        t_nrm             w_nrm_in;

        if (s == 0) begin : g_first
            // numerator a * 2^16 + norm, divisor 2 * norm
            always_comb begin
                for (int l = 0; l < 4; l++) begin
                    w_rem_in[l] = (REM_W'(i_nrm.a[l]) << 16) + REM_W'(i_root);
                    w_quo_in[l] = '0;
                end
            end
            assign w_den_in = {i_root, 1'b0};
            assign w_nrm_in = i_nrm;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_den_in = r_den[s-1];
            assign w_nrm_in = r_nrm[s-1];
        end

        assign w_sub = REM_W'(w_den_in) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nrm[s].meta.vld <= 1'b0;
            end else if (i_en) begin
                r_nrm[s] <= w_nrm_in;
                r_den[s] <= w_den_in;
                for (int l = 0; l < 4; l++) begin
                    if (w_rem_in[l] >= w_sub) begin
                        r_rem[s][l] <= w_rem_in[l] - w_sub;
                        r_quo[s][l] <= w_quo_in[l] | (QUO_W'(1) << K);
                    end else begin
                        r_rem[s][l] <= w_rem_in[l];
                        r_quo[s][l] <= w_quo_in[l];
                    end
                end
            end
        end
    end

    t_nrm             w_last;
    logic [QUO_W-1:0] w_q   [4];
    t_quat            w_res;

    assign w_last = r_nrm[QUO_W-1];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_q[l] = r_quo[QUO_W-1][l];
            if (w_last.neg[l]) begin
                if (w_q[l] > Q_NEG_MAX) begin
                    w_q[l] = Q_NEG_MAX;
                end
                w_res[l] = Q_W'(QUO_W'(0) - w_q[l]);
            end else begin
                if (w_q[l] > Q_POS_MAX) begin
                    w_q[l] = Q_POS_MAX;
                end
                w_res[l] = Q_W'(w_q[l]);
            end
        end
        if (w_last.meta.pass) begin
            w_res = w_last.meta.raw;
        end else if (w_last.zero) begin
            w_res = QUAT_IDENT;
        end
    end

    assign o_vld         = w_last.meta.vld;
    assign o_word.out_w  = w_res[0];
    assign o_word.out_x  = w_res[1];
    assign o_word.out_y  = w_res[2];
    assign o_word.out_z  = w_res[3];

endmodule

// File: rtl/bprc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprc_checker
// port-level checks on the rotation correction block
// ----------------------------------------------------------------------------
module bprc_checker import bprc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_word  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word shown after reset");

    // a refused result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result word changed");

    // input is only held off by a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> $past(o_valid && !i_ready))
        else $error("input refused without output stall");

    // with the output slot empty the input is always open
    a_empty_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input refused while output empty");

endmodule

bind per_bone_rotation_correction bprc_checker u_bprc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
